### design/pdrf_pkg.sv
// Shared types, codes and defaults for the push dispatcher with recent filter.
package pdrf_pkg;

   localparam int TableDepthDefault = 16;
   localparam int DonglesDefault = 2;
   localparam int HandlersPerDongleDefault = 4;

   localparam logic [1:0] KIND_REPORT = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [2:0] STATUS_WEAK = 3'd0;
   localparam logic [2:0] STATUS_IN_SERVICE = 3'd1;
   localparam logic [2:0] STATUS_NO_IDLE = 3'd2;
   localparam logic [2:0] STATUS_RECENT = 3'd3;
   localparam logic [2:0] STATUS_DISPATCHED = 3'd4;
   localparam logic [2:0] STATUS_ACK = 3'd5;

   localparam logic CSR_RSSI_THRESHOLD = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam logic signed [7:0] RSSI_THRESHOLD_RESET = -8'sd60;
   localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

   typedef struct packed {
      logic [1:0] kind;
      logic [47:0] device_address;
      logic signed [7:0] signal_strength;
      logic [2:0] handler_index;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] assigned_slot;
      logic table_full;
   } rsp_type;

   typedef struct packed {
      logic age;
      logic lookup;
      logic claim;
      logic write_recent;
      logic [47:0] address;
      logic [31:0] now_time;
      logic [31:0] timeout;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_AGE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

endpackage

### design/pdrf_recent_cell.sv
// One entry of the recent-address table: ageing, match and first-free chain.
module pdrf_recent_cell import pdrf_pkg::*; (
   input logic clock,
   input logic reset,
   input cell_ctl_type ctl,
   input logic chain_in,
   output logic chain_out,
   output logic match
);

   logic valid_ff, valid_in;
   logic sel_ff, sel_in;
   logic [47:0] addr_ff;
   logic [31:0] stamp_ff;
   logic [31:0] age;

   assign age = ctl.now_time - stamp_ff;
   assign chain_out = chain_in & valid_ff;
   assign match = valid_ff && (addr_ff == ctl.address);

   always_comb begin
      valid_in = valid_ff;
      sel_in = sel_ff;
      if (ctl.age && valid_ff && (age > ctl.timeout)) begin
         valid_in = 1'b0;
      end
      if (ctl.lookup) begin
         sel_in = chain_in & ~valid_ff;
      end
      if (ctl.write_recent && sel_ff) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write_recent && sel_ff) begin
         addr_ff <= ctl.address;
         stamp_ff <= ctl.now_time;
      end
   end

endmodule

### design/pdrf_handler_cell.sv
// One push handler: busy flag, served address and first-idle chain.
module pdrf_handler_cell import pdrf_pkg::*; #(
   parameter logic [2:0] SLOT_CODE = 3'd0
) (
   input logic clock,
   input logic reset,
   input cell_ctl_type ctl,
   input logic release_req,
   input logic chain_in,
   output logic chain_out,
   output logic match,
   output logic [2:0] slot_code
);

   logic busy_ff, busy_in;
   logic sel_ff, sel_in;
   logic [47:0] addr_ff;

   assign chain_out = chain_in & busy_ff;
   assign match = busy_ff && (addr_ff == ctl.address);
   assign slot_code = sel_ff ? SLOT_CODE : 3'd0;

   always_comb begin
      busy_in = busy_ff;
      sel_in = sel_ff;
      if (ctl.lookup) begin
         sel_in = chain_in & ~busy_ff;
      end
      if (ctl.claim && sel_ff) begin
         busy_in = 1'b1;
      end
      if (release_req) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.claim && sel_ff) begin
         addr_ff <= ctl.address;
      end
   end

endmodule

### design/push_dispatch_with_recent_filter.sv
// Push dispatcher top level: request register, sequencer, cell rows and result register.
// A request is captured at the edge that accepts it and then passes through ST_AGE, in
// which every recent-table cell ages its entry against the request time, ST_LOOKUP, in
// which the address is compared in every recent and handler cell while the first-free
// and first-idle tokens ripple along each row, and ST_COMMIT, in which the cells commit
// and the result register loads. The next request is taken in the cycle after the commit,
// so no request is accepted while another is in flight; a stalled result that is still
// held when the following request reaches ST_COMMIT delays that step until it is taken.
module push_dispatch_with_recent_filter import pdrf_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int DONGLES = DonglesDefault,
   parameter int HANDLERS_PER_DONGLE = HandlersPerDongleDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_write_en,
   input logic csr_index,
   input logic [31:0] csr_write_data
);

   localparam int NumHandlers = DONGLES * HANDLERS_PER_DONGLE;

   state_type state_ff, state_in;
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rssi_threshold_ff;
   logic [31:0] timeout_ff;
   logic served_ff, no_idle_ff, recent_ff, full_ff;

   cell_ctl_type ctl;
   logic [TABLE_DEPTH:0] recent_chain;
   logic [TABLE_DEPTH-1:0] recent_match;
   logic [NumHandlers:0] handler_chain;
   logic [NumHandlers-1:0] handler_match;
   logic [NumHandlers-1:0] handler_release;
   logic [2:0] handler_slot [NumHandlers];
   logic [2:0] slot;
   logic is_report, faint, commit, claim;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign is_report = (req_ff.kind == KIND_REPORT);
   assign faint = (req_ff.signal_strength <= rssi_threshold_ff);
   assign commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign claim = commit && is_report && !faint && !served_ff && !no_idle_ff && !recent_ff;

   assign ctl.age = (state_ff == ST_AGE);
   assign ctl.lookup = (state_ff == ST_LOOKUP);
   assign ctl.claim = claim;
   assign ctl.write_recent = claim && !full_ff;
   assign ctl.address = req_ff.device_address;
   assign ctl.now_time = req_ff.now_time;
   assign ctl.timeout = timeout_ff;

   assign recent_chain[0] = 1'b1;
   assign handler_chain[0] = 1'b1;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_recent
      pdrf_recent_cell u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .chain_in(recent_chain[k]),
         .chain_out(recent_chain[k+1]),
         .match(recent_match[k])
      );
   end

   for (genvar k = 0; k < NumHandlers; k++) begin : g_handler
      assign handler_release[k] = commit && (req_ff.kind == KIND_FINISH)
         && (int'(req_ff.handler_index) == k);
      pdrf_handler_cell #(
         .SLOT_CODE(3'(k))
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .release_req(handler_release[k]),
         .chain_in(handler_chain[k]),
         .chain_out(handler_chain[k+1]),
         .match(handler_match[k]),
         .slot_code(handler_slot[k])
      );
   end

   always_comb begin
      slot = 3'd0;
      for (int k = 0; k < NumHandlers; k++) begin
         slot = slot | handler_slot[k];
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_AGE;
            end
         end
         ST_AGE: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.assigned_slot = 3'd0;
               rsp_in.table_full = 1'b0;
               if (!is_report) begin
                  rsp_in.status = STATUS_ACK;
               end else if (faint) begin
                  rsp_in.status = STATUS_WEAK;
               end else if (served_ff) begin
                  rsp_in.status = STATUS_IN_SERVICE;
               end else if (no_idle_ff) begin
                  rsp_in.status = STATUS_NO_IDLE;
               end else if (recent_ff) begin
                  rsp_in.status = STATUS_RECENT;
               end else begin
                  rsp_in.status = STATUS_DISPATCHED;
                  rsp_in.assigned_slot = slot;
                  rsp_in.table_full = full_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rssi_threshold_ff <= RSSI_THRESHOLD_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_RSSI_THRESHOLD: rssi_threshold_ff <= signed'(csr_write_data[7:0]);
               CSR_TIMEOUT: timeout_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_LOOKUP) begin
         served_ff <= |handler_match;
         no_idle_ff <= handler_chain[NumHandlers];
         recent_ff <= |recent_match;
         full_ff <= recent_chain[TABLE_DEPTH];
      end
   end

endmodule

### sim/tb_push_dispatch_with_recent_filter.sv
// Self-checking testbench for the push dispatcher with recent-address filter.
module tb_push_dispatch_with_recent_filter;
   import pdrf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TBL = TableDepthDefault;
   localparam int NHND = DonglesDefault * HandlersPerDongleDefault;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [31:0] TIMEOUT_MAX = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic csr_index = CSR_RSSI_THRESHOLD;
   logic [31:0] csr_write_data = '0;

   push_dispatch_with_recent_filter u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic signed [7:0] floor_rssi;
   logic [31:0] age_limit;
   bit recent_live [TBL];
   logic [47:0] recent_addr [TBL];
   logic [31:0] recent_when [TBL];
   bit handler_on [NHND];
   logic [47:0] handler_peer [NHND];

   req_type request_backlog [$];
   rsp_type dispatch_expected [$];

   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int req_gap = 0;
   int rsp_hold = 0;
   int errors = 0;
   int requests_taken = 0;
   int status_seen [8];
   int full_seen = 0;

   logic [31:0] ms_now;
   logic [47:0] addr_pool [24];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic rsp_type predict_dispatch(input req_type r);
      rsp_type o;
      int idle;
      int free_at;
      bit served;
      bit seen;
      logic [31:0] age;
      o = '0;
      o.status = STATUS_ACK;
      idle = -1;
      free_at = -1;
      served = 1'b0;
      seen = 1'b0;
      for (int k = 0; k < TBL; k++) begin
         if (recent_live[k]) begin
            age = r.now_time - recent_when[k];
            if (age > age_limit) recent_live[k] = 1'b0;
         end
      end
      if (r.kind == KIND_FINISH) begin
         if (r.handler_index < NHND) handler_on[r.handler_index] = 1'b0;
      end else if (r.kind == KIND_REPORT) begin
         if ($signed(r.signal_strength) <= floor_rssi) begin
            o.status = STATUS_WEAK;
         end else begin
            for (int k = 0; k < NHND; k++) begin
               if (handler_on[k]) begin
                  if (handler_peer[k] == r.device_address) served = 1'b1;
               end else if (idle < 0) begin
                  idle = k;
               end
            end
            for (int k = 0; k < TBL; k++) begin
               if (recent_live[k]) begin
                  if (recent_addr[k] == r.device_address) seen = 1'b1;
               end else if (free_at < 0) begin
                  free_at = k;
               end
            end
            if (served) begin
               o.status = STATUS_IN_SERVICE;
            end else if (idle < 0) begin
               o.status = STATUS_NO_IDLE;
            end else if (seen) begin
               o.status = STATUS_RECENT;
            end else begin
               o.status = STATUS_DISPATCHED;
               o.assigned_slot = idle[2:0];
               handler_on[idle] = 1'b1;
               handler_peer[idle] = r.device_address;
               if (free_at >= 0) begin
                  recent_live[free_at] = 1'b1;
                  recent_addr[free_at] = r.device_address;
                  recent_when[free_at] = r.now_time;
               end else begin
                  o.table_full = 1'b1;
               end
            end
         end
      end
      return o;
   endfunction

   // monitor: follow register writes, predict accepted requests, check results
   always @(posedge clock) begin
      rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         floor_rssi = RSSI_THRESHOLD_RESET;
         age_limit = TIMEOUT_RESET;
         for (int k = 0; k < TBL; k++) recent_live[k] = 1'b0;
         for (int k = 0; k < NHND; k++) handler_on[k] = 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_RSSI_THRESHOLD) floor_rssi = csr_write_data[7:0];
            else age_limit = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (dispatch_expected.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_data.status, -1);
            end else begin
               want = dispatch_expected.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.assigned_slot !== want.assigned_slot)
                  report_mismatch("assigned_slot", rsp_data.assigned_slot, want.assigned_slot);
               if (rsp_data.table_full !== want.table_full)
                  report_mismatch("table_full", rsp_data.table_full, want.table_full);
               status_seen[want.status]++;
               if (want.table_full) full_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            dispatch_expected.push_back(predict_dispatch(req_data));
            requests_taken++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_fire || !req_valid) begin
         if (req_fire) req_gap = req_calm ? 0 : $urandom_range(0, 10);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            req_data <= request_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure: hold each result for a drawn number of cycles
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) rsp_hold = rsp_calm ? 0 : $urandom_range(0, 10);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            if (rsp_valid) rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_req(input logic [1:0] kind, input logic [47:0] addr, input int rssi,
                           input int hidx, input logic [31:0] stamp);
      req_type r;
      r.kind = kind;
      r.device_address = addr;
      r.signal_strength = 8'(rssi);
      r.handler_index = 3'(hidx);
      r.now_time = stamp;
      request_backlog.push_back(r);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || dispatch_expected.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_floor(input int floor);
      logic [7:0] f;
      f = 8'(floor);
      write_csr(CSR_RSSI_THRESHOLD, {{24{f[7]}}, f});
   endtask

   task automatic random_phase(input int count, input int pool_n, input int step_max,
                               input int floor, input bit calm_in, input bit calm_out);
      int pick;
      logic [1:0] kind;
      logic [47:0] addr;
      int rssi;
      req_calm = calm_in;
      rsp_calm = calm_out;
      for (int k = 0; k < pool_n; k++) addr_pool[k] = 48'({$urandom, $urandom});
      for (int n = 0; n < count; n++) begin
         ms_now += $urandom_range(0, step_max);
         if ($urandom_range(0, 39) == 0) ms_now = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 60) kind = KIND_REPORT;
         else if (pick < 85) kind = KIND_FINISH;
         else if (pick < 95) kind = KIND_TICK;
         else kind = KIND_SPARE;
         if ($urandom_range(0, 9) == 0) addr = 48'({$urandom, $urandom});
         else addr = addr_pool[$urandom_range(0, pool_n - 1)];
         if (floor < 127 && $urandom_range(0, 3) != 0)
            rssi = floor + 1 + $urandom_range(0, 126 - floor);
         else
            rssi = $urandom_range(0, 255);
         push_req(kind, addr, rssi, $urandom_range(0, 7), ms_now);
      end
      settle();
   endtask

   initial begin
      logic [31:0] t;
      int floor;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: threshold -60, timeout 10000
      t = 32'hFFFF_FF00;
      push_req(KIND_REPORT, 48'h0, -60, 0, t);
      push_req(KIND_REPORT, 48'h0, -128, 0, t);
      push_req(KIND_REPORT, 48'h0, 127, 0, t);
      push_req(KIND_REPORT, 48'h0, -59, 0, t);
      push_req(KIND_REPORT, 48'hFFFF_FFFF_FFFF, 127, 7, t);
      for (int k = 1; k <= 6; k++) push_req(KIND_REPORT, 48'(k), 10, 0, t + k);
      push_req(KIND_REPORT, 48'h7, 10, 0, t + 7);
      push_req(KIND_FINISH, 48'h0, 0, 0, t + 8);
      // wrapped time, entry still young
      push_req(KIND_REPORT, 48'h0, 0, 0, 32'h100);
      t = 32'h100 + 32'd10001;
      push_req(KIND_TICK, 48'h0, 0, 0, t);
      push_req(KIND_SPARE, 48'hFFFF_FFFF_FFFF, -1, 7, t);
      push_req(KIND_REPORT, 48'h0, 0, 0, t);
      push_req(KIND_FINISH, 48'h0, 0, 7, t);
      push_req(KIND_FINISH, 48'h0, 0, 3, t);
      push_req(KIND_REPORT, 48'h5555_5555_5555, 1, 0, t);
      // age exactly at the timeout is kept, one more frees it
      push_req(KIND_FINISH, 48'h0, 0, 0, t + 32'd10000);
      push_req(KIND_REPORT, 48'h0, 5, 0, t + 32'd10000);
      push_req(KIND_REPORT, 48'h0, 5, 0, t + 32'd10001);
      settle();

      ms_now = $urandom;
      set_floor(-128);
      write_csr(CSR_TIMEOUT, 32'd0);
      random_phase(250, 12, 3, -128, 1'b1, 1'b0);

      floor = -90 + $urandom_range(0, 60);
      set_floor(floor);
      write_csr(CSR_TIMEOUT, TIMEOUT_MAX);
      random_phase(300, 24, 50, floor, 1'b0, 1'b0);

      set_floor(127);
      write_csr(CSR_TIMEOUT, $urandom);
      random_phase(80, 8, 1000, 127, 1'b0, 1'b1);

      set_floor(-60);
      write_csr(CSR_TIMEOUT, $urandom_range(30, 300));
      random_phase(350, 16, 20, -60, 1'b0, 1'b1);

      floor = $urandom_range(0, 255) - 128;
      set_floor(floor);
      write_csr(CSR_TIMEOUT, $urandom_range(500, 5000));
      random_phase(300, 20, 100, floor, 1'b1, 1'b1);

      set_floor(-100);
      write_csr(CSR_TIMEOUT, TIMEOUT_RESET);
      random_phase(250, 16, 500, -100, 1'b0, 1'b0);

      repeat (20) @(negedge clock);
      $display("Covered %0d requests: weak %0d, in service %0d, no idle %0d, recent %0d,",
               requests_taken, status_seen[STATUS_WEAK], status_seen[STATUS_IN_SERVICE],
               status_seen[STATUS_NO_IDLE], status_seen[STATUS_RECENT]);
      $display("dispatched %0d (%0d with the recent list full), acknowledged %0d; %0d errors",
               status_seen[STATUS_DISPATCHED], full_seen, status_seen[STATUS_ACK], errors);
      if (errors == 0 && dispatch_expected.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding", dispatch_expected.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### push_dispatch_with_recent_filter.f
design/pdrf_pkg.sv
design/pdrf_recent_cell.sv
design/pdrf_handler_cell.sv
design/push_dispatch_with_recent_filter.sv
sim/tb_push_dispatch_with_recent_filter.sv
